// File: rtl/bce_pkg.sv
// bce_pkg: shared constants, types and the log2 table function
// for the binary cross-entropy loss and gradient unit; no dependencies
package bce_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int LOG_DEPTH_DEF = 256;
	localparam logic [29:0] LN2_Q30 = 30'd744261118;

	// datapath operation codes
	localparam logic [2:0] OP_LOAD    = 3'd0;
	localparam logic [2:0] OP_LOG_A   = 3'd1;
	localparam logic [2:0] OP_LOG_B   = 3'd2;
	localparam logic [2:0] OP_DIV_G   = 3'd3;
	localparam logic [2:0] OP_DIV_L   = 3'd4;
	localparam logic [2:0] OP_ACCUM   = 3'd5;
	localparam logic [2:0] OP_NONE    = 3'd6;

	typedef struct packed {
		logic       start;
		logic [2:0] op;
	} bce_cmd_t;

	typedef struct packed {
		logic busy;
	} bce_sts_t;

	// log2(1+i/depth) in Q.30, by repeated squaring (elaboration only)
	function automatic logic [31:0] log2_entry(input int i, input int depth);
		logic [63:0] v;
		logic [31:0] ip;
		logic [31:0] fr;
		v = (64'd1 << 30) + ((64'(i) << 30) / 64'(depth));
		ip = 0;
		fr = 0;
		if (v >= (64'd1 << 31)) begin
			ip = 1;
			v = v >> 1;
		end
		for (int k = 1; k <= 30; k++) begin
			v = (v * v) >> 30;
			if (v >= (64'd1 << 31)) begin
				v = v >> 1;
				fr = fr | (32'd1 << (30 - k));
			end
		end
		return (ip << 30) + fr;
	endfunction

endpackage

// File: rtl/bce_ctrl.sv
// bce_ctrl: sequencer for the loss/gradient datapath
// depends on bce_pkg
module bce_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_go,
	input  logic               last,
	input  bce_pkg::bce_sts_t  sts,
	output bce_pkg::bce_cmd_t  cmd,
	output logic               done
);
	import bce_pkg::*;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_LOGA  = 3'd1;
	localparam logic [2:0] S_LOGB  = 3'd2;
	localparam logic [2:0] S_DIVG  = 3'd3;
	localparam logic [2:0] S_ACC   = 3'd4;
	localparam logic [2:0] S_DIVL  = 3'd5;
	localparam logic [2:0] S_DONE  = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       started_q;

	// next state and command
	always_comb begin
		state_d = state_q;
		cmd.start = 1'b0;
		cmd.op = OP_NONE;
		done = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (in_go) begin
					cmd.op = OP_LOAD;
					state_d = S_LOGA;
				end
			end
			S_LOGA: begin
				cmd.op = OP_LOG_A;
				cmd.start = !started_q;
				if (started_q && !sts.busy) state_d = S_LOGB;
			end
			S_LOGB: begin
				cmd.op = OP_LOG_B;
				cmd.start = !started_q;
				if (started_q && !sts.busy) state_d = S_DIVG;
			end
			S_DIVG: begin
				cmd.op = OP_DIV_G;
				cmd.start = !started_q;
				if (started_q && !sts.busy) state_d = S_ACC;
			end
			S_ACC: begin
				cmd.op = OP_ACCUM;
				state_d = last ? S_DIVL : S_DONE;
			end
			S_DIVL: begin
				cmd.op = OP_DIV_L;
				cmd.start = !started_q;
				if (started_q && !sts.busy) state_d = S_DONE;
			end
			S_DONE: begin
				done = 1'b1;
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// state register; started flags the multi-cycle unit has been kicked
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			started_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_d != state_q) started_q <= 1'b0;
			else if (cmd.start) started_q <= 1'b1;
		end
	end

endmodule

// File: rtl/bce_dpath.sv
// bce_dpath: log interpolation, shared restoring divider, accumulator
// depends on bce_pkg
module bce_dpath #(
	parameter int FRAC_BITS = bce_pkg::FRAC_BITS_DEF,
	parameter int LOG_TABLE_DEPTH = bce_pkg::LOG_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  bce_pkg::bce_cmd_t  cmd,
	output bce_pkg::bce_sts_t  sts,
	input  logic [15:0]        x_in,
	input  logic [15:0]        y_in,
	input  logic [15:0]        loss_div,
	output logic [31:0]        grad_q,
	output logic [31:0]        loss_q
);
	import bce_pkg::*;

	localparam int IW = $clog2(LOG_TABLE_DEPTH);
	localparam int NUMW = 32 + FRAC_BITS;      // gradient numerator width
	localparam int LNUMW = 48 + ((FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0);
	localparam int QW = (NUMW > LNUMW) ? NUMW : LNUMW;
	localparam int CW = $clog2(QW + 1);
	localparam logic [47:0] SUM_MAX = {48{1'b1}};

	// log2 table, constant at elaboration
	logic [31:0] log_tab [LOG_TABLE_DEPTH+1];
	for (genvar g = 0; g <= LOG_TABLE_DEPTH; g++) begin : g_tab
		assign log_tab[g] = log2_entry(g, LOG_TABLE_DEPTH);
	end

	logic [15:0] x_q, y_q, yb_q;
	logic [33:0] a_q, b_q;
	logic [47:0] sum_q;
	logic        neg_q;

	// ---- log unit: normalize, interpolate, scale
	logic [1:0]  lstep_q;
	logic [15:0] lsrc;
	logic [4:0]  lp_q;
	logic [IW-1:0] lidx_q;
	logic [14:0] lw_q;
	logic [31:0] l_q;
	logic [4:0]  p_c;
	logic [15:0] m_c;
	logic [15+IW:0] prod_c;
	logic [IW-1:0] idx_c;
	logic [31:0] lo_c, hi_c, ln_c;
	logic [46:0] dl_c;
	logic [34:0] nl_c;
	logic [63:0] sc_c;

	assign lsrc = (cmd.op == OP_LOG_A) ? y_q : yb_q;

	// leading one search over 16 bits
	always_comb begin
		p_c = 5'd0;
		for (int k = 1; k < 16; k++) if (lsrc[k]) p_c = 5'(k);
		m_c = lsrc << (5'd15 - p_c);
		prod_c = (16+IW)'(m_c - 16'd32768) * (16+IW)'(LOG_TABLE_DEPTH);
		idx_c = (prod_c[15+IW:15] > (IW+1)'(LOG_TABLE_DEPTH - 1)) ?
			IW'(LOG_TABLE_DEPTH - 1) : prod_c[14+IW:15];
		lo_c = log_tab[{1'b0, lidx_q}];
		hi_c = log_tab[{1'b0, lidx_q} + (IW+1)'(1)];
		dl_c = 47'(hi_c - lo_c) * 47'(lw_q);
		ln_c = lo_c + 32'(dl_c >> 15);
		nl_c = ({30'd0, 5'd16 - lp_q} << 30) - 35'(l_q);
		sc_c = 64'(nl_c) * 64'(LN2_Q30);
	end

	// ---- shared restoring divider, one quotient bit per cycle
	logic [QW-1:0] dnum_q, dquo_q;
	logic [QW:0]   drem_q;
	logic [32:0]   dden_q;
	logic [CW-1:0] dcnt_q;
	logic          dbusy_q;
	logic [QW:0]   rsh_c;
	logic [QW:0]   rsub_c;

	always_comb begin
		rsh_c = {drem_q[QW-1:0], dnum_q[QW-1]};
		rsub_c = rsh_c - (QW+1)'(dden_q);
	end

	logic [15:0] diff_c;
	logic [15:0] bs_c;
	logic [QW-1:0] lnum_c;
	assign diff_c = (x_q > y_q) ? x_q - y_q : y_q - x_q;
	assign bs_c = (loss_div == 16'd0) ? 16'd1 : loss_div;
	generate
		if (FRAC_BITS >= 16) begin : g_up
			assign lnum_c = QW'({sum_q, {(FRAC_BITS-16+1){1'b0}}} >> 1);
		end else begin : g_dn
			assign lnum_c = QW'(sum_q >> (16 - FRAC_BITS));
		end
	endgenerate

	// term: x*a + xb*b, then >>30
	logic [16:0] xb_c;
	logic [49:0] ta_c, tb_c;
	logic [49:0] ta_q, tb_q;
	logic [50:0] tsum_c;
	logic [48:0] nsum_c;
	assign xb_c = 17'd65536 - 17'(x_q);
	assign ta_c = 50'(x_q) * 50'(a_q);
	assign tb_c = 50'(xb_c) * 50'(b_q);
	assign tsum_c = 51'(ta_q) + 51'(tb_q);
	assign nsum_c = 49'(sum_q) + 49'(tsum_c >> 30);

	logic [QW-1:0] q_fin;
	assign q_fin = dquo_q;

	assign sts.busy = dbusy_q || (lstep_q != 2'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lstep_q <= 2'd0;
			dbusy_q <= 1'b0;
			sum_q <= '0;
		end else begin
			case (cmd.op)
				OP_LOAD: begin
					x_q <= x_in;
					y_q <= (y_in == 16'd0) ? 16'd1 : y_in;
					yb_q <= 16'(17'd65536 - 17'((y_in == 16'd0) ? 16'd1 : y_in));
					neg_q <= x_in > ((y_in == 16'd0) ? 16'd1 : y_in);
				end
				OP_LOG_A, OP_LOG_B: begin
					if (cmd.start) begin
						lp_q <= p_c;
						lidx_q <= idx_c;
						lw_q <= prod_c[14:0];
						lstep_q <= 2'd1;
					end else if (lstep_q == 2'd1) begin
						l_q <= ln_c;
						lstep_q <= 2'd2;
					end else if (lstep_q == 2'd2) begin
						if (cmd.op == OP_LOG_A) a_q <= 34'(sc_c >> 30);
						else b_q <= 34'(sc_c >> 30);
						lstep_q <= 2'd0;
					end
				end
				OP_DIV_G, OP_DIV_L: begin
					if (cmd.start) begin
						ta_q <= ta_c;
						tb_q <= tb_c;
						if (cmd.op == OP_DIV_G) begin
							dnum_q <= QW'({diff_c, {(16+FRAC_BITS){1'b0}}});
							dden_q <= 33'(y_q) * 33'(yb_q);
						end else begin
							dnum_q <= lnum_c;
							dden_q <= 33'(bs_c);
						end
						drem_q <= '0;
						dquo_q <= '0;
						dcnt_q <= CW'(QW);
						dbusy_q <= 1'b1;
					end else if (dbusy_q) begin
						dnum_q <= dnum_q << 1;
						if (!rsub_c[QW]) begin
							drem_q <= rsub_c;
							dquo_q <= {dquo_q[QW-2:0], 1'b1};
						end else begin
							drem_q <= rsh_c;
							dquo_q <= {dquo_q[QW-2:0], 1'b0};
						end
						dcnt_q <= dcnt_q - CW'(1);
						if (dcnt_q == CW'(1)) dbusy_q <= 1'b0;
					end else if (cmd.op == OP_DIV_G) begin
						if (neg_q) grad_q <= (q_fin >= QW'(32'h80000000)) ?
							32'h80000000 : 32'(~q_fin + QW'(1));
						else grad_q <= (q_fin > QW'(32'h7FFFFFFF)) ?
							32'h7FFFFFFF : q_fin[31:0];
					end else begin
						loss_q <= (q_fin > QW'(32'hFFFFFFFF)) ?
							32'hFFFFFFFF : q_fin[31:0];
						sum_q <= '0;
					end
				end
				OP_ACCUM: begin
					sum_q <= nsum_c[48] ? SUM_MAX : nsum_c[47:0];
					loss_q <= '0;
				end
				default: ;
			endcase
		end
	end

endmodule

// File: rtl/binary_cross_entropy_loss_grad_unit.sv
// Binary cross-entropy loss and gradient unit: one item (target, prediction,
// last flag) in, one word out with the gradient and, on the last item, the
// averaged loss. Items are processed one at a time: two table-interpolated
// logarithms, then a shared one-bit-per-cycle divider (start, quotient bits,
// finish) for the gradient, and the same again for the loss divide on a
// last item. in_stall stays high until the result word is taken, so a new
// item is accepted only after the previous word has left the output.
// No clearing pass after reset.
// top level; depends on bce_pkg, bce_ctrl, bce_dpath
module binary_cross_entropy_loss_grad_unit #(
	parameter int FRAC_BITS = bce_pkg::FRAC_BITS_DEF,
	parameter int LOG_TABLE_DEPTH = bce_pkg::LOG_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [15:0] target_value,
	input  logic [15:0] prediction,
	input  logic        last_element,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] gradient,
	output logic [31:0] loss,
	output logic        loss_valid,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data
);
	import bce_pkg::*;

	logic        busy_q;
	logic        last_q;
	logic [15:0] bs_q;
	logic        in_go, done;
	bce_cmd_t    cmd;
	bce_sts_t    sts;
	logic [31:0] grad_w, loss_w;

	assign cfg_ready = 1'b1;
	// one item in flight or waiting at the output
	assign in_stall = busy_q;
	assign in_go = in_valid && !busy_q;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) bs_q <= 16'd1;
		else if (cfg_valid) bs_q <= cfg_data;
	end

	// item occupancy and output word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (in_go) begin
				busy_q <= 1'b1;
				last_q <= last_element;
			end
			if (done) begin
				out_valid <= 1'b1;
				gradient <= grad_w;
				loss <= last_q ? loss_w : 32'd0;
				loss_valid <= last_q;
			end else if (out_valid && !out_stall) begin
				out_valid <= 1'b0;
				busy_q <= 1'b0;
			end
		end
	end

	bce_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_go(in_go), .last(last_q),
		.sts(sts), .cmd(cmd), .done(done)
	);

	bce_dpath #(.FRAC_BITS(FRAC_BITS), .LOG_TABLE_DEPTH(LOG_TABLE_DEPTH)) u_dpath (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.x_in(target_value), .y_in(prediction), .loss_div(bs_q),
		.grad_q(grad_w), .loss_q(loss_w)
	);

endmodule

// File: test/binary_cross_entropy_loss_grad_unit_tb.sv
// testbench for binary_cross_entropy_loss_grad_unit: drives random and directed words,
// predicts gradient and averaged loss bit for bit, checks every output word in order
// depends on rtl/bce_pkg.sv and rtl/binary_cross_entropy_loss_grad_unit.sv
module binary_cross_entropy_loss_grad_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int FB = bce_pkg::FRAC_BITS_DEF;
	localparam int DEPTH = bce_pkg::LOG_DEPTH_DEF;
	localparam logic [63:0] LN2 = 64'(bce_pkg::LN2_Q30);
	localparam logic [63:0] ACC_MAX = (64'd1 << 48) - 64'd1;

	typedef struct {
		logic [15:0] tgt;
		logic [15:0] pred;
		logic        last;
	} sample_t;

	typedef struct {
		logic [31:0] grad;
		logic [31:0] loss;
		logic        lv;
	} bce_word_t;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        in_valid = 0;
	logic        in_stall;
	logic [15:0] target_value = 0;
	logic [15:0] prediction = 0;
	logic        last_element = 0;
	logic        out_valid;
	logic        out_stall = 0;
	logic [31:0] gradient;
	logic [31:0] loss;
	logic        loss_valid;
	logic        cfg_valid = 0;
	logic        cfg_ready;
	logic [15:0] cfg_data = 0;

	sample_t     pending_q[$];
	bce_word_t   expected_q[$];
	logic [31:0] log2_tab[DEPTH+1];
	logic [63:0] loss_acc = 0;
	logic [15:0] batch_div = 16'd1;
	int          errors = 0;
	int          burst_left = 0;
	int          gap_left = 0;
	int          stall_mode = 0;
	int          stall_left = 0;

	binary_cross_entropy_loss_grad_unit dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.target_value(target_value), .prediction(prediction), .last_element(last_element),
		.out_valid(out_valid), .out_stall(out_stall),
		.gradient(gradient), .loss(loss), .loss_valid(loss_valid),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	always #2 clk = ~clk;

	// log2 of a Q.30 value in [1,2] by repeated squaring
	function automatic logic [31:0] log2_fix(input logic [63:0] val);
		logic [63:0] v;
		logic [31:0] whole;
		logic [31:0] frac;
		v = val;
		whole = 0;
		frac = 0;
		if (v >= (64'd1 << 31)) begin
			whole = 1;
			v = v >> 1;
		end
		for (int k = 1; k <= 30; k++) begin
			v = (v * v) >> 30;
			if (v >= (64'd1 << 31)) begin
				v = v >> 1;
				frac = frac | (32'd1 << (30 - k));
			end
		end
		return (whole << 30) + frac;
	endfunction

	// -ln(y/65536) in Q.30 with table interpolation
	function automatic logic [63:0] neg_ln_q30(input logic [16:0] y);
		int          msb;
		logic [15:0] mant;
		logic [63:0] prod;
		logic [31:0] idx;
		logic [63:0] wt;
		logic [63:0] lg;
		logic [127:0] nl;
		msb = 15;
		while (msb > 0 && y[msb] == 1'b0) msb--;
		mant = 16'(y << (15 - msb));
		prod = 64'(mant - 16'd32768) * DEPTH;
		idx = 32'(prod >> 15);
		if (idx > DEPTH - 1) idx = DEPTH - 1;
		wt = prod & 64'h7FFF;
		lg = 64'(log2_tab[idx]) + (((64'(log2_tab[idx+1] - log2_tab[idx])) * wt) >> 15);
		nl = 128'((64'(16 - msb) << 30) - lg);
		return 64'((nl * LN2) >> 30);
	endfunction

	// gradient, loss term and end-of-set average for one accepted word
	function automatic bce_word_t predict_bce(input sample_t s);
		bce_word_t   r;
		logic [16:0] y;
		logic [16:0] x;
		logic [16:0] yb;
		logic [16:0] xb;
		logic        neg;
		logic [63:0] diff;
		logic [63:0] mag;
		logic [63:0] term;
		logic [63:0] avg;
		logic [63:0] bs;
		x = {1'b0, s.tgt};
		y = (s.pred == 0) ? 17'd1 : {1'b0, s.pred};
		xb = 17'd65536 - x;
		yb = 17'd65536 - y;
		neg = x > y;
		diff = neg ? 64'(x - y) : 64'(y - x);
		mag = (diff << (16 + FB)) / (64'(y) * 64'(yb));
		if (neg) r.grad = (mag >= 64'h80000000) ? 32'h80000000 : 32'(64'h100000000 - mag);
		else r.grad = (mag > 64'h7FFFFFFF) ? 32'h7FFFFFFF : 32'(mag);
		term = (64'(x) * neg_ln_q30(y) + 64'(xb) * neg_ln_q30(yb)) >> 30;
		loss_acc = loss_acc + term;
		if (loss_acc > ACC_MAX) loss_acc = ACC_MAX;
		r.loss = 0;
		r.lv = s.last;
		if (s.last) begin
			bs = (batch_div == 0) ? 64'd1 : 64'(batch_div);
			if (FB >= 16) avg = (loss_acc << (FB - 16)) / bs;
			else avg = (loss_acc >> (16 - FB)) / bs;
			r.loss = (avg > 64'hFFFFFFFF) ? 32'hFFFFFFFF : 32'(avg);
			loss_acc = 0;
		end
		return r;
	endfunction

	// input driver: bursts and gaps, holds a word until accepted
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 0;
		end else begin
			if (in_valid && !in_stall) begin
				expected_q.push_back(predict_bce(pending_q[0]));
				pending_q.pop_front();
			end
			if (in_valid && in_stall) begin
				// keep word stable while stalled
			end else if (gap_left > 0) begin
				gap_left--;
				in_valid <= 0;
			end else if (pending_q.size() > 0) begin
				in_valid <= 1;
				target_value <= pending_q[0].tgt;
				prediction <= pending_q[0].pred;
				last_element <= pending_q[0].last;
				if (burst_left > 0) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(0, 30);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 150);
				end
			end else begin
				in_valid <= 0;
			end
		end
	end

	// output monitor: random stall pattern, compare against oldest prediction
	always @(posedge clk) begin
		bce_word_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_q.size() == 0) begin
				$error("unexpected output word gradient=%h loss=%h", gradient, loss);
				errors++;
			end else begin
				e = expected_q.pop_front();
				if (gradient !== e.grad) begin
					$error("gradient exp %h got %h", e.grad, gradient);
					errors++;
				end
				if (loss !== e.loss) begin
					$error("loss exp %h got %h", e.loss, loss);
					errors++;
				end
				if (loss_valid !== e.lv) begin
					$error("loss_valid exp %b got %b", e.lv, loss_valid);
					errors++;
				end
			end
		end
		if (stall_left == 0) begin
			stall_mode = $urandom_range(0, 3);
			stall_left = $urandom_range(20, 400);
		end else begin
			stall_left--;
		end
		case (stall_mode)
			0: out_stall <= 0;
			1: out_stall <= ($urandom_range(0, 9) < 3);
			2: out_stall <= ($urandom_range(0, 9) < 8);
			default: out_stall <= ($urandom_range(0, 199) == 0) ? 1'b1 : out_stall ^ ($urandom_range(0, 15) == 0);
		endcase
	end

	task automatic push_sample(input logic [15:0] t, input logic [15:0] p, input logic l);
		sample_t s;
		s.tgt = t;
		s.pred = p;
		s.last = l;
		pending_q.push_back(s);
	endtask

	task automatic write_batch(input logic [15:0] v);
		@(posedge clk);
		cfg_valid <= 1;
		cfg_data <= v;
		do @(posedge clk); while (!(cfg_valid && cfg_ready));
		batch_div = v;
		cfg_valid <= 0;
	endtask

	task automatic drain_all();
		while (pending_q.size() > 0 || expected_q.size() > 0 || in_valid) @(posedge clk);
		repeat (150) @(posedge clk);
	endtask

	function automatic logic [15:0] rand_field(input bit nonzero);
		logic [15:0] v;
		case ($urandom_range(0, 7))
			0: v = nonzero ? 16'd1 : 16'd0;
			1: v = 16'hFFFF;
			2: v = 16'($urandom_range(0, 255));
			3: v = 16'hFFFF - 16'($urandom_range(0, 255));
			default: v = 16'($urandom);
		endcase
		if (nonzero && v == 0 && $urandom_range(0, 19) != 0) v = 1;
		return v;
	endfunction

	// stimulus sequence
	initial begin
		logic [15:0] settings[6];
		int set_left;
		settings = '{16'd3, 16'hFFFF, 16'd0, 16'd1, 16'($urandom), 16'($urandom_range(2, 20))};
		repeat (10) @(posedge clk);
		arst_n <= 1;
		repeat (3) @(posedge clk);

		// directed corners at reset batch size
		push_sample(16'd0, 16'd1, 0);
		push_sample(16'hFFFF, 16'd1, 0);
		push_sample(16'd0, 16'hFFFF, 0);
		push_sample(16'hFFFF, 16'hFFFF, 1);
		push_sample(16'd32768, 16'd32768, 1);
		push_sample(16'd0, 16'd0, 0);
		push_sample(16'hFFFF, 16'd0, 1);
		push_sample(16'd1, 16'hFFFF, 0);
		push_sample(16'hFFFE, 16'd2, 0);
		push_sample(16'd12345, 16'd54321, 0);
		push_sample(16'd40000, 16'd100, 1);
		push_sample(16'd32767, 16'd32769, 1);
		drain_all();
		write_batch(16'hFFFF);
		push_sample(16'hFFFF, 16'd1, 0);
		push_sample(16'd0, 16'hFFFF, 1);
		drain_all();

		// random phases over several batch sizes
		foreach (settings[i]) begin
			write_batch(settings[i]);
			set_left = $urandom_range(1, 8);
			for (int n = 0; n < 305; n++) begin
				set_left--;
				push_sample(rand_field(0), rand_field(1), (set_left == 0) || (n == 304));
				if (set_left == 0) set_left = ($urandom_range(0, 4) == 0) ? 1 : $urandom_range(1, 12);
			end
			drain_all();
		end

		if (errors == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

	// table of log2(1+i/depth)
	initial begin
		for (int i = 0; i <= DEPTH; i++)
			log2_tab[i] = log2_fix((64'd1 << 30) + ((64'(i) << 30) / 64'(DEPTH)));
	end

	// run limit
	initial begin
		#20ms;
		$display("RESULT: ERROR");
		$finish;
	end
endmodule

// File: binary_cross_entropy_loss_grad_unit.f
rtl/bce_pkg.sv
rtl/bce_ctrl.sv
rtl/bce_dpath.sv
rtl/binary_cross_entropy_loss_grad_unit.sv
test/binary_cross_entropy_loss_grad_unit_tb.sv
